// ===== sv/bptb_pkg.sv =====
`default_nettype none

package bptb_pkg;

    localparam int unsigned FIELD_W    = 20;
    localparam int unsigned TOTAL_W    = 22;
    localparam int unsigned PERIOD_W   = 24;
    localparam int unsigned UNIT_W     = 18;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned DUTY_W     = 25;
    localparam int unsigned STEP_OUT_W = 17;
    localparam int unsigned ACC_W      = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd1000000;
    localparam logic [7:0]          PERCENT      = 8'd100;

    // Reciprocal of 100 scaled by 2^31, rounded up; exact for 24-bit periods.
    localparam int unsigned         UNIT_SHIFT   = 31;
    localparam logic [24:0]         UNIT_RECIP   = 25'd21474837;

    typedef struct packed {
        logic                 repeat_mode;
        logic [FIELD_W-1:0]   fade_ms;
        logic [FIELD_W-1:0]   hold_on_ms;
        logic [FIELD_W-1:0]   hold_off_ms;
        logic [7:0]           low_grade;
        logic [7:0]           high_grade;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0]      entry_index;
        logic [DUTY_W-1:0]     duty_value;
        logic                  is_control;
        logic [STEP_OUT_W-1:0] step_time_ms;
        logic [IDX_W-1:0]      entry_count;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic                  repeat_mode;
        logic [STEP_OUT_W-1:0] step_time_ms;
        logic [IDX_W-1:0]      entry_count;
        logic [IDX_W-1:0]      fade_end;
        logic [IDX_W-1:0]      plateau_end;
        logic [IDX_W-1:0]      fall_end;
        logic [PCT_W-1:0]      lo;
        logic [PCT_W-1:0]      hi;
        logic [PCT_W-1:0]      ramp;
        logic [UNIT_W-1:0]     unit;
    } desc_t;

    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] dividend;
        logic [TOTAL_W-1:0] divisor;
    } div_cmd_t;

    // Grade 0..255 to percent 0..100, floor(g*100/255).
    function automatic logic [PCT_W-1:0] grade_to_pct(input logic [7:0] g);
        logic [14:0] x;
        logic [15:0] s;
        begin
            x = 15'(g) * 15'(PERCENT);
            s = 16'(x) + 16'd1 + 16'(x[14:8]);
            grade_to_pct = s[14:8];
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/breath_pattern_table_builder_core.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         push / full          request_t
// result    out        pop / empty          result_t
// cfg       in         cfg_valid/cfg_ready  pwm_period_ns, 24 bits
//
// A request holds the front for four passes of the shared radix-2 divider (three
// when there is no ramp), each one iteration per quotient bit and a done strobe,
// plus the setup and push states. The back then loads the descriptor, scales the
// levels, and writes one table entry per cycle plus the control entry.
// The front takes a new request once its setup is queued; the back drains
// entries into a two-deep result queue and stalls only when that queue is full.
// Reset clears all control state and sets the period to 1000000 ns.

module breath_pattern_table_builder_core
    import bptb_pkg::*;
#(
    parameter int unsigned TABLE_STEPS = 41
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  request_t            request,
    input  wire                 pop,
    output logic                empty,
    output result_t             result,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [PERIOD_W-1:0]  cfg_data
);

    logic [PERIOD_W-1:0] period_reg;
    logic                front_busy;
    logic                desc_push;
    desc_t               desc_wr;
    logic                desc_full;
    desc_t               desc_rd;
    logic                desc_empty;
    logic                desc_pop;
    logic                out_push;
    result_t             out_item;
    logic                out_full;

    assign cfg_ready = 1'b1;
    assign full      = front_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg <= cfg_data;
        end
    end

    bptb_front #(
        .TABLE_STEPS (TABLE_STEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .busy      (front_busy),
        .period    (period_reg),
        .desc_push (desc_push),
        .desc      (desc_wr),
        .desc_full (desc_full)
    );

    bptb_queue #(
        .item_t (desc_t),
        .DEPTH  (2)
    ) u_desc_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_item (desc_wr),
        .q_full  (desc_full),
        .rd_en   (desc_pop),
        .rd_item (desc_rd),
        .q_empty (desc_empty)
    );

    bptb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (desc_rd),
        .desc_empty (desc_empty),
        .desc_pop   (desc_pop),
        .out_push   (out_push),
        .out_item   (out_item),
        .out_full   (out_full)
    );

    bptb_queue #(
        .item_t (result_t),
        .DEPTH  (2)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_item (out_item),
        .q_full  (out_full),
        .rd_en   (pop),
        .rd_item (result),
        .q_empty (empty)
    );

endmodule

`default_nettype wire

// ===== sv/bptb_queue.sv =====
`default_nettype none

module bptb_queue
    import bptb_pkg::*;
#(
    parameter type         item_t = logic,
    parameter int unsigned DEPTH  = 2
)
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   wr_en,
    input  item_t wr_item,
    output logic  q_full,
    input  wire   rd_en,
    output item_t rd_item,
    output logic  q_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bptb_div.sv =====
`default_nettype none

module bptb_div
    import bptb_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  div_cmd_t            cmd,
    output logic                done,
    output logic [TOTAL_W-1:0]  quotient
);

    localparam int unsigned CNT_W = $clog2(TOTAL_W + 1);

    logic [TOTAL_W-1:0] rem_reg;
    logic [TOTAL_W-1:0] quo_reg;
    logic [TOTAL_W-1:0] dsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [TOTAL_W:0]   shifted;
    logic [TOTAL_W:0]   diff;
    logic               fits;

    assign shifted  = {rem_reg, quo_reg[TOTAL_W-1]};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign fits     = (shifted >= {1'b0, dsr_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= '0;
            quo_reg <= cmd.dividend;
            dsr_reg <= cmd.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
            quo_reg <= {quo_reg[TOTAL_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TOTAL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bptb_front.sv =====
`default_nettype none

module bptb_front
    import bptb_pkg::*;
#(
    parameter int unsigned TABLE_STEPS = 41
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  request_t            request,
    output logic                busy,
    input  wire [PERIOD_W-1:0]  period,
    output logic                desc_push,
    output desc_t               desc,
    input  wire                 desc_full
);

    localparam int unsigned STEP_SHIFT = 28;
    localparam int unsigned RECIP_W    = 28;
    localparam logic [RECIP_W-1:0] STEP_RECIP =
        RECIP_W'((64'd1 << STEP_SHIFT) / 64'(TABLE_STEPS) + 64'd1);
    localparam logic [TOTAL_W-1:0] STEPS_T = TOTAL_W'(TABLE_STEPS);

    typedef enum logic [3:0] {
        F_IDLE, F_STEP, F_UNIT, F_DFADE, F_DON, F_DOFF, F_LEVEL, F_DRAMP, F_PUSH
    } fstate_t;

    fstate_t             state_reg;
    request_t            req_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  step_reg;
    logic [UNIT_W-1:0]   unit_reg;
    logic [PCT_W-1:0]    hi_reg;
    logic [PCT_W-1:0]    lo_reg;
    logic [TOTAL_W-1:0]  nfade_reg;
    logic [TOTAL_W-1:0]  non_reg;
    logic [TOTAL_W-1:0]  noff_reg;
    logic [PCT_W-1:0]    ramp_reg;
    logic [IDX_W-1:0]    count_reg;
    logic [IDX_W-1:0]    fade_end_reg;
    logic [IDX_W-1:0]    plat_end_reg;
    logic [IDX_W-1:0]    fall_end_reg;

    div_cmd_t               div_cmd;
    logic                   div_done;
    logic [TOTAL_W-1:0]     div_q;
    logic [TOTAL_W-1:0]     cur_time;
    logic [TOTAL_W+RECIP_W-1:0] step_prod;
    logic [TOTAL_W-1:0]     step_raw;
    logic [48:0]            unit_prod;
    logic [TOTAL_W-1:0]     q_fixed;
    logic [TOTAL_W+1:0]     sum_plat;
    logic [TOTAL_W+1:0]     sum_fall;
    logic [TOTAL_W+1:0]     sum_all;
    logic [PCT_W-1:0]       hi_pct;
    logic                   ramp_go;

    bptb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .done     (div_done),
        .quotient (div_q)
    );

    assign busy      = (state_reg != F_IDLE);
    assign step_prod = total_reg * STEP_RECIP;
    assign step_raw  = step_prod[TOTAL_W+STEP_SHIFT-1:STEP_SHIFT];
    assign unit_prod = period * UNIT_RECIP;
    assign q_fixed   = ((div_q == '0) && (cur_time != '0)) ? TOTAL_W'(1) : div_q;
    assign sum_plat  = (TOTAL_W+2)'(nfade_reg) + (TOTAL_W+2)'(non_reg);
    assign sum_fall  = sum_plat + (TOTAL_W+2)'(nfade_reg);
    assign sum_all   = sum_fall + (TOTAL_W+2)'(noff_reg);
    assign hi_pct    = grade_to_pct(req_reg.high_grade);
    assign ramp_go   = (nfade_reg != '0) && (lo_reg <= hi_reg);

    // The division in progress belongs to the current state; the one started
    // when it completes uses the next stage time.
    always_comb
    begin
        div_cmd.start    = 1'b0;
        div_cmd.dividend = TOTAL_W'(req_reg.fade_ms);
        div_cmd.divisor  = step_reg;
        cur_time         = TOTAL_W'(req_reg.fade_ms);
        case (state_reg)
            F_UNIT:
            begin
                div_cmd.dividend = TOTAL_W'(req_reg.fade_ms);
                div_cmd.start    = 1'b1;
            end
            F_DFADE:
            begin
                cur_time         = TOTAL_W'(req_reg.fade_ms);
                div_cmd.dividend = TOTAL_W'(req_reg.hold_on_ms);
                div_cmd.start    = div_done;
            end
            F_DON:
            begin
                cur_time         = TOTAL_W'(req_reg.hold_on_ms);
                div_cmd.dividend = TOTAL_W'(req_reg.hold_off_ms);
                div_cmd.start    = div_done;
            end
            F_DOFF:
            begin
                cur_time         = TOTAL_W'(req_reg.hold_off_ms);
                div_cmd.dividend = TOTAL_W'(req_reg.hold_off_ms);
            end
            F_LEVEL:
            begin
                div_cmd.dividend = TOTAL_W'(hi_reg - lo_reg);
                div_cmd.divisor  = nfade_reg;
                div_cmd.start    = ramp_go;
            end
            F_DRAMP:
            begin
                div_cmd.dividend = TOTAL_W'(hi_reg - lo_reg);
                div_cmd.divisor  = nfade_reg;
            end
            default:
            begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            desc_push <= 1'b0;
        end
        else
        begin
            desc_push <= 1'b0;
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        state_reg <= F_STEP;
                    end
                end
                F_STEP:
                begin
                    state_reg <= F_UNIT;
                end
                F_UNIT:
                begin
                    state_reg <= F_DFADE;
                end
                F_DFADE:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_DON;
                    end
                end
                F_DON:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_DOFF;
                    end
                end
                F_DOFF:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_LEVEL;
                    end
                end
                F_LEVEL:
                begin
                    state_reg <= ramp_go ? F_DRAMP : F_PUSH;
                end
                F_DRAMP:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!desc_full)
                    begin
                        desc_push <= 1'b1;
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                req_reg   <= request;
                total_reg <= {1'b0, request.fade_ms, 1'b0}
                           + TOTAL_W'(request.hold_on_ms)
                           + TOTAL_W'(request.hold_off_ms);
                ramp_reg  <= '0;
            end
            F_STEP:
            begin
                step_reg <= (step_raw == '0) ? TOTAL_W'(1) : step_raw;
                hi_reg   <= ((hi_pct == '0) && (req_reg.high_grade != '0))
                            ? PCT_W'(1) : hi_pct;
                lo_reg   <= grade_to_pct(req_reg.low_grade);
            end
            F_UNIT:
            begin
                unit_reg <= unit_prod[UNIT_SHIFT+UNIT_W-1:UNIT_SHIFT];
            end
            F_DFADE:
            begin
                if (div_done)
                begin
                    nfade_reg <= q_fixed;
                end
            end
            F_DON:
            begin
                if (div_done)
                begin
                    non_reg <= q_fixed;
                end
            end
            F_DOFF:
            begin
                if (div_done)
                begin
                    noff_reg <= q_fixed;
                end
            end
            F_LEVEL:
            begin
                fade_end_reg <= (nfade_reg > STEPS_T) ? IDX_W'(TABLE_STEPS)
                                                      : nfade_reg[IDX_W-1:0];
                plat_end_reg <= (sum_plat > (TOTAL_W+2)'(STEPS_T)) ? IDX_W'(TABLE_STEPS)
                                                                   : sum_plat[IDX_W-1:0];
                fall_end_reg <= (sum_fall > (TOTAL_W+2)'(STEPS_T)) ? IDX_W'(TABLE_STEPS)
                                                                   : sum_fall[IDX_W-1:0];
                count_reg    <= (sum_all > (TOTAL_W+2)'(STEPS_T)) ? IDX_W'(TABLE_STEPS)
                                                                  : sum_all[IDX_W-1:0];
            end
            F_DRAMP:
            begin
                if (div_done)
                begin
                    if ((div_q == '0) && (req_reg.high_grade != req_reg.low_grade)
                        && (req_reg.high_grade != '0))
                    begin
                        ramp_reg <= PCT_W'(1);
                    end
                    else
                    begin
                        ramp_reg <= div_q[PCT_W-1:0];
                    end
                end
            end
            default:
            begin
                ramp_reg <= ramp_reg;
            end
        endcase
    end

    always_comb
    begin
        desc.repeat_mode  = req_reg.repeat_mode;
        desc.step_time_ms = step_reg[STEP_OUT_W-1:0];
        desc.entry_count  = count_reg;
        desc.fade_end     = fade_end_reg;
        desc.plateau_end  = plat_end_reg;
        desc.fall_end     = fall_end_reg;
        desc.lo           = lo_reg;
        desc.hi           = hi_reg;
        desc.ramp         = ramp_reg;
        desc.unit         = unit_reg;
    end

endmodule

`default_nettype wire

// ===== sv/bptb_back.sv =====
`default_nettype none

module bptb_back
    import bptb_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  desc_t     desc,
    input  wire       desc_empty,
    output logic      desc_pop,
    output logic      out_push,
    output result_t   out_item,
    input  wire       out_full
);

    typedef enum logic [2:0] {
        B_IDLE, B_MUL_LO, B_MUL_HI, B_MUL_RAMP, B_EMIT, B_CTRL
    } bstate_t;

    bstate_t            state_reg;
    desc_t              job_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [ACC_W-1:0]   rise_reg;
    logic [ACC_W-1:0]   held_reg;
    logic [ACC_W-1:0]   dec_reg;
    logic [ACC_W-1:0]   hi_u_reg;
    logic [ACC_W-1:0]   ramp_u_reg;

    logic [PCT_W-1:0]        mul_a;
    logic [PCT_W+UNIT_W-1:0] mul_p;
    logic [ACC_W-1:0]        duty;
    logic                    emit;

    assign desc_pop = (state_reg == B_IDLE) && !desc_empty;
    assign emit     = (state_reg == B_EMIT) && !out_full;

    always_comb
    begin
        case (state_reg)
            B_MUL_HI:   mul_a = job_reg.hi;
            B_MUL_RAMP: mul_a = job_reg.ramp;
            default:    mul_a = job_reg.lo;
        endcase
    end

    assign mul_p = mul_a * job_reg.unit;

    always_comb
    begin
        if (idx_reg < job_reg.fade_end)
        begin
            duty = rise_reg;
        end
        else if (idx_reg < job_reg.plateau_end)
        begin
            duty = (hi_u_reg < held_reg) ? held_reg : hi_u_reg;
        end
        else if (idx_reg < job_reg.fall_end)
        begin
            duty = (held_reg < dec_reg) ? '0 : held_reg - dec_reg;
        end
        else
        begin
            duty = '0;
        end
    end

    always_comb
    begin
        out_item.entry_count  = job_reg.entry_count;
        out_item.step_time_ms = job_reg.step_time_ms;
        if (state_reg == B_CTRL)
        begin
            out_item.entry_index = job_reg.entry_count;
            out_item.duty_value  = DUTY_W'(job_reg.repeat_mode);
            out_item.is_control  = 1'b1;
            out_item.last        = 1'b1;
        end
        else
        begin
            out_item.entry_index = idx_reg;
            out_item.duty_value  = duty[DUTY_W-1:0];
            out_item.is_control  = 1'b0;
            out_item.last        = 1'b0;
        end
    end

    assign out_push = emit || ((state_reg == B_CTRL) && !out_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (!desc_empty)
                    begin
                        state_reg <= B_MUL_LO;
                    end
                end
                B_MUL_LO:
                begin
                    state_reg <= B_MUL_HI;
                end
                B_MUL_HI:
                begin
                    state_reg <= B_MUL_RAMP;
                end
                B_MUL_RAMP:
                begin
                    state_reg <= (job_reg.entry_count == '0) ? B_CTRL : B_EMIT;
                end
                B_EMIT:
                begin
                    if (emit && (idx_reg + 1'b1 == job_reg.entry_count))
                    begin
                        state_reg <= B_CTRL;
                    end
                end
                B_CTRL:
                begin
                    if (!out_full)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg  <= desc;
                idx_reg  <= '0;
                held_reg <= '0;
                dec_reg  <= '0;
            end
            B_MUL_LO:
            begin
                rise_reg <= ACC_W'(mul_p);
            end
            B_MUL_HI:
            begin
                hi_u_reg <= ACC_W'(mul_p);
            end
            B_MUL_RAMP:
            begin
                ramp_u_reg <= ACC_W'(mul_p);
            end
            B_EMIT:
            begin
                if (emit)
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg < job_reg.fade_end)
                    begin
                        held_reg <= rise_reg;
                        rise_reg <= rise_reg + ramp_u_reg;
                    end
                    else if ((idx_reg >= job_reg.plateau_end)
                             && (idx_reg < job_reg.fall_end))
                    begin
                        dec_reg <= dec_reg + ramp_u_reg;
                    end
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result written into a full queue");

    a_ctrl_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_item.is_control) |-> (out_item.entry_index == out_item.entry_count))
        else $error("control entry not at the table end");

    a_duty_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && !out_item.is_control) |-> (out_item.entry_index < out_item.entry_count))
        else $error("duty entry beyond the table end");

    a_ctrl_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_item.is_control) |=> (state_reg == B_IDLE))
        else $error("sequencer did not return to idle after the control entry");
`endif

endmodule

`default_nettype wire
